// ----- sv/pba_pkg.sv -----
// pba_pkg: shared types and codes for the paged bitmap first-fit allocator
// holds opcode and status codes and the packed transaction structs
// depends on nothing
package pba_pkg;

  localparam int OPCODE_W = 2;
  localparam int SIZE_W   = 13;
  localparam int HANDLE_W = 14;
  localparam int STATUS_W = 2;

  // request codes
  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  // result codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 2'd0,
    ST_BAD_SIZE      = 2'd1,
    ST_NO_MEMORY     = 2'd2,
    ST_NOT_ALLOCATED = 2'd3
  } status_t;

  // input transaction
  typedef struct packed {
    opcode_t               opcode;
    logic [SIZE_W-1:0]     size_bytes;
    logic [HANDLE_W-1:0]   free_handle;
  } in_item_t;

  // result transaction
  typedef struct packed {
    status_t               status;
    logic [HANDLE_W-1:0]   handle;
  } out_item_t;

endpackage

// ----- sv/pba_ram.sv -----
// pba_ram: generic simple dual-port memory, one write and one registered read port
// read data is registered and appears in the cycle after the read enable
// depends on nothing
module pba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/pba_fit.sv -----
// pba_fit: first-fit window search over one page bitmap
// finds the lowest start block whose run of free blocks fits the request
// depends on nothing
module pba_fit #(
  parameter int BPP = 16
) (
  input  logic [BPP-1:0]             free_word,
  input  logic [$clog2(BPP+1)-1:0]   blocks,
  output logic                       found,
  output logic [$clog2(BPP)-1:0]     start_blk
);

  // scan start positions from the top so the lowest fitting one wins
  always_comb begin
    logic ok;
    found     = 1'b0;
    start_blk = '0;
    ok        = 1'b0;
    for (int s = BPP - 1; s >= 0; s--) begin
      ok = (s + int'(blocks)) <= BPP;
      for (int i = 0; i < BPP; i++) begin
        if (i >= s && i < s + int'(blocks) && !free_word[i]) begin
          ok = 1'b0;
        end
      end
      if (ok) begin
        found     = 1'b1;
        start_blk = ($clog2(BPP))'(s);
      end
    end
  end

endmodule

// ----- sv/paged_bitmap_first_fit_allocator.sv -----
// paged_bitmap_first_fit_allocator: top level, request sequencer and state memories
// uses pba_pkg, pba_ram (page bitmaps, run lengths) and pba_fit (window search)
// one request in flight at a time
//
// A request is taken when start is high and busy is low; exactly one result follows,
// shown on out_item for one cycle with out_strobe, and it cannot be held off.
// A bad size, clear or unused opcode answers from idle; a free whose handle lies past
// the last page or is not block aligned answers from the block check, any other free
// after its run length and bitmap read. An allocate answers from the claim state, both
// when it fits in the last page scanned and when it opens a new page (straight to
// claim when no page is open yet), and from the scan state when memory is exhausted.
// The page scan reads one bitmap word per cycle from the bitmap memory, so allocate
// time grows with the number of open pages. Busy is low again in the cycle the result
// is shown. Both memories come out of reset and clear usable at once: per-entry valid
// bits stand in for the cleared contents, so there is no clearing pass.
module paged_bitmap_first_fit_allocator #(
  parameter int PAGES           = 4,
  parameter int BLOCKS_PER_PAGE = 16,
  parameter int BLOCK_BYTES     = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  pba_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output pba_pkg::out_item_t out_item
);

  localparam int BPP        = BLOCKS_PER_PAGE;
  localparam int PAGE_BYTES = BPP * BLOCK_BYTES;
  localparam int SLOTS      = PAGES * BPP;
  localparam int PG_W       = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int PO_W       = $clog2(PAGES + 1);
  localparam int BLK_W      = $clog2(BPP);
  localparam int LEN_W      = $clog2(BPP + 1);
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int HW         = pba_pkg::HANDLE_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_CLAIM = 5'b00100,
    S_FBLK  = 5'b01000,
    S_FCHK  = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [PG_W-1:0]     page_r, page_nxt;
  logic [LEN_W-1:0]    blocks_r, blocks_nxt;
  logic [BLK_W-1:0]    start_r, start_nxt;
  logic                open_r, open_nxt;
  logic [BPP-1:0]      fmw_r, fmw_nxt;
  logic [HW-1:0]       offset_r, offset_nxt;
  logic                pg_ok_r, pg_ok_nxt;
  logic [BLK_W-1:0]    blk_r, blk_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [PO_W-1:0]     pages_open_r, pages_open_nxt;
  logic [PAGES-1:0]    fm_vld_r, fm_vld_nxt;
  logic [SLOTS-1:0]    rl_vld_r, rl_vld_nxt;
  logic                out_strobe_r;
  pba_pkg::out_item_t  out_item_r;

  logic                res_vld;
  pba_pkg::out_item_t  res;

  logic                fm_we, fm_re;
  logic [PG_W-1:0]     fm_waddr, fm_raddr;
  logic [BPP-1:0]      fm_wdata, fm_rdata, fm_word;
  logic                rl_we, rl_re;
  logic [SLOT_W-1:0]   rl_waddr, rl_raddr;
  logic [LEN_W-1:0]    rl_wdata, rl_rdata, rl_len;

  logic                fit_found;
  logic [BLK_W-1:0]    fit_start;

  logic                sz_ok;
  logic [LEN_W-1:0]    sz_blocks;
  logic                hd_ok;
  logic [PG_W-1:0]     hd_page;
  logic [31:0]         hd_base;
  logic                blk_hit;
  logic [BLK_W-1:0]    blk_idx;

  // mask of a run of n blocks beginning at block st
  function automatic logic [BPP-1:0] run_mask(input logic [BLK_W-1:0] st,
                                              input logic [LEN_W-1:0] n);
    logic [BPP-1:0] m;
    m = '0;
    for (int i = 0; i < BPP; i++) begin
      m[i] = (i >= int'(st)) && (i < int'(st) + int'(n));
    end
    return m;
  endfunction

  // run length table index of a block
  function automatic logic [SLOT_W-1:0] slot_of(input logic [PG_W-1:0] pg,
                                                input logic [BLK_W-1:0] bk);
    return SLOT_W'(32'(pg) * BPP + 32'(bk));
  endfunction

  // byte address of a block
  function automatic logic [HW-1:0] addr_of(input logic [PG_W-1:0] pg,
                                            input logic [BLK_W-1:0] bk);
    return HW'(32'(pg) * PAGE_BYTES + 32'(bk) * BLOCK_BYTES);
  endfunction

  // page bitmaps
  pba_ram #(.WIDTH(BPP), .DEPTH(PAGES)) u_fm_ram (
    .clk   (clk),
    .we    (fm_we),
    .waddr (fm_waddr),
    .wdata (fm_wdata),
    .re    (fm_re),
    .raddr (fm_raddr),
    .rdata (fm_rdata)
  );

  // run length at each start block
  pba_ram #(.WIDTH(LEN_W), .DEPTH(SLOTS)) u_rl_ram (
    .clk   (clk),
    .we    (rl_we),
    .waddr (rl_waddr),
    .wdata (rl_wdata),
    .re    (rl_re),
    .raddr (rl_raddr),
    .rdata (rl_rdata)
  );

  // entries never written since reset or clear read as free / no run
  assign fm_word = fm_vld_r[page_r] ? fm_rdata : '1;
  assign rl_len  = rl_vld_r[slot_r] ? rl_rdata : '0;

  pba_fit #(.BPP(BPP)) u_fit (
    .free_word (fm_word),
    .blocks    (blocks_r),
    .found     (fit_found),
    .start_blk (fit_start)
  );

  // size decode: exact match against each whole-block size
  always_comb begin
    sz_ok     = 1'b0;
    sz_blocks = '0;
    for (int b = 1; b <= BPP; b++) begin
      if (32'(in_item.size_bytes) == 32'(b * BLOCK_BYTES)) begin
        sz_ok     = 1'b1;
        sz_blocks = LEN_W'(b);
      end
    end
  end

  // handle decode: page range compare
  always_comb begin
    hd_ok   = 1'b0;
    hd_page = '0;
    hd_base = '0;
    for (int p = 0; p < PAGES; p++) begin
      if (32'(in_item.free_handle) >= 32'(p * PAGE_BYTES) &&
          32'(in_item.free_handle) < 32'((p + 1) * PAGE_BYTES)) begin
        hd_ok   = 1'b1;
        hd_page = PG_W'(p);
        hd_base = 32'(p * PAGE_BYTES);
      end
    end
  end

  // block decode of the registered page offset, aligned offsets only
  always_comb begin
    blk_hit = 1'b0;
    blk_idx = '0;
    for (int b = 0; b < BPP; b++) begin
      if (32'(offset_r) == 32'(b * BLOCK_BYTES)) begin
        blk_hit = 1'b1;
        blk_idx = BLK_W'(b);
      end
    end
  end

  // request sequencer
  always_comb begin
    state_nxt      = state_r;
    page_nxt       = page_r;
    blocks_nxt     = blocks_r;
    start_nxt      = start_r;
    open_nxt       = open_r;
    fmw_nxt        = fmw_r;
    offset_nxt     = offset_r;
    pg_ok_nxt      = pg_ok_r;
    blk_nxt        = blk_r;
    slot_nxt       = slot_r;
    pages_open_nxt = pages_open_r;
    fm_vld_nxt     = fm_vld_r;
    rl_vld_nxt     = rl_vld_r;
    fm_we          = 1'b0;
    fm_waddr       = page_r;
    fm_wdata       = fmw_r;
    fm_re          = 1'b0;
    fm_raddr       = page_r;
    rl_we          = 1'b0;
    rl_waddr       = slot_of(page_r, start_r);
    rl_wdata       = blocks_r;
    rl_re          = 1'b0;
    rl_raddr       = slot_r;
    res_vld        = 1'b0;
    res.status     = pba_pkg::ST_OK;
    res.handle     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          blocks_nxt = sz_blocks;
          offset_nxt = HW'(32'(in_item.free_handle) - hd_base);
          pg_ok_nxt  = hd_ok;
          unique case (in_item.opcode)
            pba_pkg::OP_ALLOC: begin
              if (!sz_ok) begin
                res_vld    = 1'b1;
                res.status = pba_pkg::ST_BAD_SIZE;
              end else if (pages_open_r == '0) begin
                page_nxt  = '0;
                fmw_nxt   = '1;
                start_nxt = '0;
                open_nxt  = 1'b1;
                state_nxt = S_CLAIM;
              end else begin
                fm_re     = 1'b1;
                fm_raddr  = '0;
                page_nxt  = '0;
                state_nxt = S_SCAN;
              end
            end
            pba_pkg::OP_FREE: begin
              page_nxt  = hd_page;
              state_nxt = S_FBLK;
            end
            pba_pkg::OP_CLEAR: begin
              fm_vld_nxt = '0;
              rl_vld_nxt = '0;
              res_vld    = 1'b1;
            end
            default: begin
              res_vld = 1'b1;
            end
          endcase
        end
      end

      // one open page per cycle, next page read issued on a miss
      S_SCAN: begin
        if (fit_found) begin
          start_nxt = fit_start;
          fmw_nxt   = fm_word;
          open_nxt  = 1'b0;
          state_nxt = S_CLAIM;
        end else if (32'(page_r) + 32'd1 < 32'(pages_open_r)) begin
          fm_re    = 1'b1;
          fm_raddr = page_r + PG_W'(1);
          page_nxt = page_r + PG_W'(1);
        end else if (32'(pages_open_r) >= PAGES) begin
          res_vld    = 1'b1;
          res.status = pba_pkg::ST_NO_MEMORY;
          state_nxt  = S_IDLE;
        end else begin
          page_nxt  = PG_W'(pages_open_r);
          fmw_nxt   = '1;
          start_nxt = '0;
          open_nxt  = 1'b1;
          state_nxt = S_CLAIM;
        end
      end

      // write back the claimed bitmap and record the run
      S_CLAIM: begin
        fm_we    = 1'b1;
        fm_wdata = fmw_r & ~run_mask(start_r, blocks_r);
        fm_vld_nxt[page_r] = 1'b1;
        rl_we    = 1'b1;
        rl_vld_nxt[slot_of(page_r, start_r)] = 1'b1;
        if (open_r) begin
          pages_open_nxt = pages_open_r + PO_W'(1);
        end
        res_vld    = 1'b1;
        res.handle = addr_of(page_r, start_r);
        state_nxt  = S_IDLE;
      end

      // free: check page range and alignment, then read run length and bitmap
      S_FBLK: begin
        if (!pg_ok_r || !blk_hit) begin
          res_vld    = 1'b1;
          res.status = pba_pkg::ST_NOT_ALLOCATED;
          state_nxt  = S_IDLE;
        end else begin
          rl_re     = 1'b1;
          rl_raddr  = slot_of(page_r, blk_idx);
          fm_re     = 1'b1;
          fm_raddr  = page_r;
          slot_nxt  = slot_of(page_r, blk_idx);
          blk_nxt   = blk_idx;
          state_nxt = S_FCHK;
        end
      end

      // free: release the run if one starts here
      S_FCHK: begin
        res_vld   = 1'b1;
        state_nxt = S_IDLE;
        if (rl_len == '0 || 32'(blk_r) + 32'(rl_len) > BPP) begin
          res.status = pba_pkg::ST_NOT_ALLOCATED;
        end else begin
          fm_we    = 1'b1;
          fm_wdata = fm_word | run_mask(blk_r, rl_len);
          fm_vld_nxt[page_r] = 1'b1;
          rl_vld_nxt[slot_r] = 1'b0;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pages_open_r <= '0;
      fm_vld_r     <= '0;
      rl_vld_r     <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pages_open_r <= pages_open_nxt;
      fm_vld_r     <= fm_vld_nxt;
      rl_vld_r     <= rl_vld_nxt;
      out_strobe_r <= res_vld;
    end
  end

  // working and result payload registers
  always_ff @(posedge clk) begin
    page_r   <= page_nxt;
    blocks_r <= blocks_nxt;
    start_r  <= start_nxt;
    open_r   <= open_nxt;
    fmw_r    <= fmw_nxt;
    offset_r <= offset_nxt;
    pg_ok_r  <= pg_ok_nxt;
    blk_r    <= blk_nxt;
    slot_r   <= slot_nxt;
    if (res_vld) begin
      out_item_r <= res;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

`ifndef SYNTHESIS
  // open page count stays within the page budget
  a_pages_open: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pages_open_r) <= PAGES)
    else $error("open page count exceeds page budget");

  // a result is shown only once the sequencer is free again
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while busy");

  // clear answers in the next cycle
  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.opcode == pba_pkg::OP_CLEAR) |=> out_strobe)
    else $error("clear did not answer in one cycle");

  // failed transactions carry a zero handle
  a_err_handle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.status != pba_pkg::ST_OK) |-> out_item.handle == '0)
    else $error("error result with nonzero handle");
`endif

endmodule
